/* rtl/gqv_pkg.sv */
// ----------------------------------------------------------------------------
// gqv_pkg
// Types and constants for the glyph quad vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gqv_pkg;

  localparam int POS_W      = 20;
  localparam int TEX_W      = 16;
  localparam int LH_W       = 10;
  localparam int CODE_W     = 8;
  localparam int MET_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int VTX_CNT_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_HEIGHT = 2'd2;

  localparam logic [LH_W-1:0]  LINE_HEIGHT_RST = 10'd16;
  localparam logic [TEX_W-1:0] INV_CELL_RST    = 16'd4096;

  // request types
  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_GLYPH = 1'b1;

  // special character codes
  localparam logic [CODE_W-1:0] CODE_NUL     = 8'd0;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

  // newline adds this many pixels of leading to line_height
  localparam logic [LH_W-1:0] NL_LEADING = 10'd4;

  // ceil(2^16 / 3), exact for dividends below 2^14
  localparam logic [14:0] RECIP3 = 15'd21846;

  localparam logic [VTX_CNT_W-1:0] VTX_FIRST = 3'd0;
  localparam logic [VTX_CNT_W-1:0] VTX_LAST  = 3'd5;

  typedef struct packed {
    logic [TEX_W-1:0] atlas_u;
    logic [MET_W-1:0] advance_y;
    logic [MET_W-1:0] advance_x;
    logic [MET_W-1:0] glyph_height;
    logic [MET_W-1:0] glyph_width;
    logic [MET_W-1:0] bearing_y;
    logic [MET_W-1:0] bearing_x;
  } glyph_entry_t;

endpackage

`default_nettype wire

/* rtl/glyph_quad_vertex_generator_core.sv */
// ----------------------------------------------------------------------------
// glyph_quad_vertex_generator_core
// Character stream to glyph-atlas quads: metrics table, pen, vertex emitter.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  request type, code, end flag, glyph metrics
//  out      out_valid/out_stall  one vertex: position, texcoord, flags
//  cfg      cfg_valid/cfg_ready  register index, write data
//
//  A rendered character gives six vertices, one per cycle while out_stall is
//  low; glyph writes and silent characters give none. The first vertex
//  follows the table read, then quad setup. The table has no reset state.
//  Control resets synchronously on rst_n low. out_stall holds the vertex and
//  backs up through the setup stage to in_stall; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_quad_vertex_generator_core #(
  parameter int GLYPH_COUNT = 128
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // input words
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire                                    in_req_type,
  input  wire [gqv_pkg::CODE_W-1:0]              in_char_code,
  input  wire                                    in_end_of_string,
  input  wire signed [gqv_pkg::MET_W-1:0]        in_bearing_x,
  input  wire signed [gqv_pkg::MET_W-1:0]        in_bearing_y,
  input  wire [gqv_pkg::MET_W-1:0]               in_glyph_width,
  input  wire [gqv_pkg::MET_W-1:0]               in_glyph_height,
  input  wire signed [gqv_pkg::MET_W-1:0]        in_advance_x,
  input  wire signed [gqv_pkg::MET_W-1:0]        in_advance_y,
  input  wire [gqv_pkg::TEX_W-1:0]               in_atlas_u,
  // output words
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [gqv_pkg::POS_W-1:0]       out_vert_x,
  output logic signed [gqv_pkg::POS_W-1:0]       out_vert_y,
  output logic [gqv_pkg::TEX_W-1:0]              out_tex_u,
  output logic [gqv_pkg::TEX_W-1:0]              out_tex_v,
  output logic                                   out_is_hole,
  output logic                                   out_last_vertex,
  // configuration
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [gqv_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire [gqv_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int POS_W = gqv_pkg::POS_W;
  localparam int TEX_W = gqv_pkg::TEX_W;

  // configuration registers
  logic [gqv_pkg::LH_W-1:0] line_height_r;
  logic [TEX_W-1:0]         inv_cell_width_r;
  logic [TEX_W-1:0]         inv_cell_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_height_r     <= gqv_pkg::LINE_HEIGHT_RST;
      inv_cell_width_r  <= gqv_pkg::INV_CELL_RST;
      inv_cell_height_r <= gqv_pkg::INV_CELL_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == gqv_pkg::REG_LINE_HEIGHT) begin
        line_height_r <= cfg_wdata[gqv_pkg::LH_W-1:0];
      end
      if (cfg_index == gqv_pkg::REG_INV_CELL_WIDTH) begin
        inv_cell_width_r <= cfg_wdata;
      end
      if (cfg_index == gqv_pkg::REG_INV_CELL_HEIGHT) begin
        inv_cell_height_r <= cfg_wdata;
      end
    end
  end

  // input accept and glyph table
  logic in_accept;
  logic in_range;
  logic [IDX_W-1:0] tbl_addr;
  gqv_pkg::glyph_entry_t wr_entry;
  gqv_pkg::glyph_entry_t glyph_mem [GLYPH_COUNT];
  gqv_pkg::glyph_entry_t rd_entry_r;

  assign in_accept = in_valid && !in_stall;
  assign in_range  = ({1'b0, in_char_code} < 9'(GLYPH_COUNT));
  assign tbl_addr  = in_char_code[IDX_W-1:0];

  always_comb begin
    wr_entry.atlas_u      = in_atlas_u;
    wr_entry.advance_y    = in_advance_y;
    wr_entry.advance_x    = in_advance_x;
    wr_entry.glyph_height = in_glyph_height;
    wr_entry.glyph_width  = in_glyph_width;
    wr_entry.bearing_y    = in_bearing_y;
    wr_entry.bearing_x    = in_bearing_x;
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_range) begin
      if (in_req_type == gqv_pkg::REQ_GLYPH) begin
        glyph_mem[tbl_addr] <= wr_entry;
      end else begin
        rd_entry_r <= glyph_mem[tbl_addr];
      end
    end
  end

  // setup stage
  logic                       s1_v_r;
  logic [gqv_pkg::CODE_W-1:0] s1_code_r;
  logic                       s1_eos_r;
  logic                       s1_in_range_r;
  logic                       s1_load;

  assign s1_load = in_accept && (in_req_type == gqv_pkg::REQ_CHAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= 1'b1;
    end else if (in_stall == 1'b0) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_code_r     <= in_char_code;
      s1_eos_r      <= in_end_of_string;
      s1_in_range_r <= in_range;
    end
  end

  // pen state
  logic [POS_W-1:0] pen_x_r, pen_x_nxt;
  logic [POS_W-1:0] pen_y_r, pen_y_nxt;
  logic             stopped_r, stopped_nxt;

  // quad setup arithmetic
  logic             is_nul, is_nl, is_sp, is_empty, glyph_ok, s1_emit;
  logic [POS_W-1:0] lh16, bx16, by16, ax16, ay16, w16, h16;
  logic [POS_W-1:0] xa, xb, ya, yb;
  logic [13:0]      sp_num;
  logic [28:0]      sp_prod;
  logic [POS_W-1:0] sp_adv, nl_adv;
  logic [23:0]      uw_prod, vh_prod;
  logic [24:0]      u1_sum;
  logic [TEX_W-1:0] u1_sat, v1_sat;

  always_comb begin
    is_nul   = (s1_code_r == gqv_pkg::CODE_NUL);
    is_nl    = (s1_code_r == gqv_pkg::CODE_NEWLINE);
    is_sp    = (s1_code_r == gqv_pkg::CODE_SPACE);
    is_empty = (rd_entry_r.glyph_width == '0) || (rd_entry_r.glyph_height == '0);
    glyph_ok = !is_nul && !is_nl && !is_sp && s1_in_range_r && !is_empty;
    s1_emit  = !stopped_r && (is_nl || is_sp || glyph_ok);

    lh16 = {6'b0, line_height_r, 4'b0};
    bx16 = {{8{rd_entry_r.bearing_x[7]}}, rd_entry_r.bearing_x, 4'b0};
    by16 = {{8{rd_entry_r.bearing_y[7]}}, rd_entry_r.bearing_y, 4'b0};
    ax16 = {{8{rd_entry_r.advance_x[7]}}, rd_entry_r.advance_x, 4'b0};
    ay16 = {{8{rd_entry_r.advance_y[7]}}, rd_entry_r.advance_y, 4'b0};
    w16  = {8'b0, rd_entry_r.glyph_width, 4'b0};
    h16  = {8'b0, rd_entry_r.glyph_height, 4'b0};

    xa = pen_x_r + bx16;
    xb = pen_x_r + bx16 + w16;
    ya = pen_y_r + lh16 - by16;
    yb = pen_y_r + lh16 - by16 + h16;

    sp_num  = {line_height_r, 4'b0} + 14'd1;
    sp_prod = 29'(sp_num) * 29'(gqv_pkg::RECIP3);
    sp_adv  = POS_W'(sp_prod[28:16]);
    nl_adv  = lh16 + {6'b0, gqv_pkg::NL_LEADING, 4'b0};

    uw_prod = 24'(rd_entry_r.glyph_width) * 24'(inv_cell_width_r);
    vh_prod = 24'(rd_entry_r.glyph_height) * 24'(inv_cell_height_r);
    u1_sum  = 25'(rd_entry_r.atlas_u) + 25'(uw_prod);
    u1_sat  = (|u1_sum[24:16]) ? '1 : u1_sum[15:0];
    v1_sat  = (|vh_prod[23:16]) ? '1 : vh_prod[15:0];
  end

  // emitter
  logic                          em_v_r;
  logic [gqv_pkg::VTX_CNT_W-1:0] em_k_r;
  logic [POS_W-1:0]              em_xa_r, em_xb_r, em_ya_r, em_yb_r;
  logic [TEX_W-1:0]              em_u0_r, em_u1_r, em_v1_r;
  logic                          em_hole_r;
  logic                          out_take, em_done, s1_adv, sel_b_x, sel_b_y;

  assign out_take = em_v_r && !out_stall;
  assign em_done  = out_take && (em_k_r == gqv_pkg::VTX_LAST);
  assign s1_adv   = s1_v_r && (!s1_emit || !em_v_r || em_done);
  assign in_stall = s1_v_r && !s1_adv;

  always_comb begin
    pen_x_nxt   = pen_x_r;
    pen_y_nxt   = pen_y_r;
    stopped_nxt = stopped_r;
    if (s1_eos_r) begin
      pen_x_nxt   = '0;
      pen_y_nxt   = '0;
      stopped_nxt = 1'b0;
    end else if (!stopped_r) begin
      priority if (is_nul) begin
        stopped_nxt = 1'b1;
      end else if (is_nl) begin
        pen_x_nxt = '0;
        pen_y_nxt = pen_y_r + nl_adv;
      end else if (is_sp) begin
        pen_x_nxt = pen_x_r + sp_adv;
      end else if (glyph_ok) begin
        pen_x_nxt = pen_x_r + ax16;
        pen_y_nxt = pen_y_r + ay16;
      end else begin
        pen_x_nxt = pen_x_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      stopped_r <= 1'b0;
    end else if (s1_adv) begin
      pen_x_r   <= pen_x_nxt;
      pen_y_r   <= pen_y_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r <= 1'b0;
      em_k_r <= gqv_pkg::VTX_FIRST;
    end else if (s1_adv && s1_emit) begin
      em_v_r <= 1'b1;
      em_k_r <= gqv_pkg::VTX_FIRST;
    end else if (em_done) begin
      em_v_r <= 1'b0;
    end else if (out_take) begin
      em_k_r <= em_k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      em_hole_r <= is_nl;
      if (glyph_ok) begin
        em_xa_r <= xa;
        em_xb_r <= xb;
        em_ya_r <= ya;
        em_yb_r <= yb;
        em_u0_r <= rd_entry_r.atlas_u;
        em_u1_r <= u1_sat;
        em_v1_r <= v1_sat;
      end else begin
        em_xa_r <= '0;
        em_xb_r <= '0;
        em_ya_r <= '0;
        em_yb_r <= '0;
        em_u0_r <= '0;
        em_u1_r <= '0;
        em_v1_r <= '0;
      end
    end
  end

  // corner order: (a,a) (a,b) (b,b) (a,a) (b,b) (b,a)
  always_comb begin
    sel_b_x = (em_k_r == 3'd2) || (em_k_r == 3'd4) || (em_k_r == 3'd5);
    sel_b_y = (em_k_r == 3'd1) || (em_k_r == 3'd2) || (em_k_r == 3'd4);
    out_valid       = em_v_r;
    out_vert_x      = sel_b_x ? em_xb_r : em_xa_r;
    out_vert_y      = sel_b_y ? em_yb_r : em_ya_r;
    out_tex_u       = sel_b_x ? em_u1_r : em_u0_r;
    out_tex_v       = sel_b_y ? em_v1_r : '0;
    out_is_hole     = em_hole_r;
    out_last_vertex = (em_k_r == gqv_pkg::VTX_LAST);
  end

endmodule

`default_nettype wire

/* rtl/gqv_checker.sv */
// ----------------------------------------------------------------------------
// gqv_checker
// Port-level checks for the glyph quad vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

module gqv_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [gqv_pkg::POS_W-1:0]         out_vert_x,
  input wire [gqv_pkg::POS_W-1:0]         out_vert_y,
  input wire [gqv_pkg::TEX_W-1:0]         out_tex_u,
  input wire [gqv_pkg::TEX_W-1:0]         out_tex_v,
  input wire                              out_is_hole,
  input wire                              out_last_vertex
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vert_x) &&
      $stable(out_vert_y) && $stable(out_tex_u) && $stable(out_tex_v) &&
      $stable(out_is_hole) && $stable(out_last_vertex))
    else $error("out word changed under stall");

  // six vertices of a run go out without a gap
  a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_vertex |=> out_valid)
    else $error("vertex run broken");

  // newline placeholders carry no geometry
  a_hole_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_hole |-> out_vert_x == '0 && out_vert_y == '0 &&
      out_tex_u == '0 && out_tex_v == '0)
    else $error("hole vertex not zero");

  // input only backs up behind a pending vertex
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall without pending output");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind glyph_quad_vertex_generator_core gqv_checker u_gqv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_vert_x      (out_vert_x),
  .out_vert_y      (out_vert_y),
  .out_tex_u       (out_tex_u),
  .out_tex_v       (out_tex_v),
  .out_is_hole     (out_is_hole),
  .out_last_vertex (out_last_vertex)
);

`default_nettype wire

/* verif/tb_glyph_quad_vertex_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_quad_vertex_generator_core
// Drives glyph-table writes and character strings into the quad generator,
// predicts every vertex from a behavioral pen and metrics-table model and
// checks each output word field by field, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_glyph_quad_vertex_generator_core;

  localparam int GLYPH_COUNT    = 128;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic                             req_type;
    logic [gqv_pkg::CODE_W-1:0]       code;
    logic                             eos;
    logic signed [gqv_pkg::MET_W-1:0] bearing_x;
    logic signed [gqv_pkg::MET_W-1:0] bearing_y;
    logic [gqv_pkg::MET_W-1:0]        glyph_width;
    logic [gqv_pkg::MET_W-1:0]        glyph_height;
    logic signed [gqv_pkg::MET_W-1:0] advance_x;
    logic signed [gqv_pkg::MET_W-1:0] advance_y;
    logic [gqv_pkg::TEX_W-1:0]        atlas_u;
  } char_word_t;

  typedef struct {
    logic signed [gqv_pkg::POS_W-1:0] x;
    logic signed [gqv_pkg::POS_W-1:0] y;
    logic [gqv_pkg::TEX_W-1:0]        u;
    logic [gqv_pkg::TEX_W-1:0]        v;
    logic                             hole;
    logic                             last;
  } vertex_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_req_type;
  logic [gqv_pkg::CODE_W-1:0]       in_char_code;
  logic                             in_end_of_string;
  logic signed [gqv_pkg::MET_W-1:0] in_bearing_x;
  logic signed [gqv_pkg::MET_W-1:0] in_bearing_y;
  logic [gqv_pkg::MET_W-1:0]        in_glyph_width;
  logic [gqv_pkg::MET_W-1:0]        in_glyph_height;
  logic signed [gqv_pkg::MET_W-1:0] in_advance_x;
  logic signed [gqv_pkg::MET_W-1:0] in_advance_y;
  logic [gqv_pkg::TEX_W-1:0]        in_atlas_u;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [gqv_pkg::POS_W-1:0] out_vert_x;
  logic signed [gqv_pkg::POS_W-1:0] out_vert_y;
  logic [gqv_pkg::TEX_W-1:0]        out_tex_u;
  logic [gqv_pkg::TEX_W-1:0]        out_tex_v;
  logic                             out_is_hole;
  logic                             out_last_vertex;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [gqv_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [gqv_pkg::CFG_DATA_W-1:0]   cfg_wdata;

  // pen and table model
  gqv_pkg::glyph_entry_t     metrics_tbl [GLYPH_COUNT];
  bit                        loaded_map [GLYPH_COUNT];
  int                        loaded_codes [$];
  logic [gqv_pkg::POS_W-1:0] pen_x;
  logic [gqv_pkg::POS_W-1:0] pen_y;
  logic                      string_muted;
  int                        line_h;
  int                        inv_w;
  int                        inv_h;
  vertex_t                   pending_vertices [$];

  int mismatch_count = 0;
  int words_sent = 0;
  bit in_gaps_on;
  bit out_gaps_on;
  int hold_off_req;

  glyph_quad_vertex_generator_core #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_char_code    (in_char_code),
    .in_end_of_string(in_end_of_string),
    .in_bearing_x    (in_bearing_x),
    .in_bearing_y    (in_bearing_y),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_advance_x    (in_advance_x),
    .in_advance_y    (in_advance_y),
    .in_atlas_u      (in_atlas_u),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_vert_x      (out_vert_x),
    .out_vert_y      (out_vert_y),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_is_hole     (out_is_hole),
    .out_last_vertex (out_last_vertex),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [gqv_pkg::POS_W-1:0] q4(
    input logic signed [gqv_pkg::MET_W-1:0] v);
    return gqv_pkg::POS_W'(int'(v) * 16);
  endfunction

  function automatic void queue_vertex(input int k, input logic [gqv_pkg::POS_W-1:0] x,
                                       input logic [gqv_pkg::POS_W-1:0] y, input int u,
                                       input int v, input logic hole);
    vertex_t vt;
    vt.x    = x;
    vt.y    = y;
    vt.u    = gqv_pkg::TEX_W'(u);
    vt.v    = gqv_pkg::TEX_W'(v);
    vt.hole = hole;
    vt.last = (k == int'(gqv_pkg::VTX_LAST));
    pending_vertices.push_back(vt);
  endfunction

  function automatic void predict_vertices(input char_word_t w);
    gqv_pkg::glyph_entry_t     e;
    logic [gqv_pkg::POS_W-1:0] x2;
    logic [gqv_pkg::POS_W-1:0] y2;
    logic [gqv_pkg::POS_W-1:0] w16;
    logic [gqv_pkg::POS_W-1:0] h16;
    int                        u0;
    int                        u1;
    int                        v1;
    int                        k;
    if (w.req_type == gqv_pkg::REQ_GLYPH) begin
      if (int'(w.code) < GLYPH_COUNT) begin
        e.bearing_x    = w.bearing_x;
        e.bearing_y    = w.bearing_y;
        e.glyph_width  = w.glyph_width;
        e.glyph_height = w.glyph_height;
        e.advance_x    = w.advance_x;
        e.advance_y    = w.advance_y;
        e.atlas_u      = w.atlas_u;
        metrics_tbl[w.code] = e;
        if (!loaded_map[w.code]) begin
          loaded_map[w.code] = 1'b1;
          loaded_codes.push_back(int'(w.code));
        end
      end
      return;
    end
    if (!string_muted) begin
      if (w.code == gqv_pkg::CODE_NUL) begin
        string_muted = 1'b1;
      end else if (w.code == gqv_pkg::CODE_NEWLINE) begin
        pen_y = pen_y + gqv_pkg::POS_W'((line_h + int'(gqv_pkg::NL_LEADING)) * 16);
        pen_x = '0;
        for (k = 0; k < 6; k++) queue_vertex(k, '0, '0, 0, 0, 1'b1);
      end else if (w.code == gqv_pkg::CODE_SPACE) begin
        pen_x = pen_x + gqv_pkg::POS_W'((line_h * 16 + 1) / 3);
        for (k = 0; k < 6; k++) queue_vertex(k, '0, '0, 0, 0, 1'b0);
      end else if (int'(w.code) < GLYPH_COUNT) begin
        e = metrics_tbl[w.code];
        if (e.glyph_width != '0 && e.glyph_height != '0) begin
          x2  = pen_x + q4(e.bearing_x);
          y2  = pen_y + gqv_pkg::POS_W'(line_h * 16) - q4(e.bearing_y);
          w16 = gqv_pkg::POS_W'(int'(e.glyph_width) * 16);
          h16 = gqv_pkg::POS_W'(int'(e.glyph_height) * 16);
          u0  = int'(e.atlas_u);
          u1  = u0 + int'(e.glyph_width) * inv_w;
          if (u1 > 65535) u1 = 65535;
          v1  = int'(e.glyph_height) * inv_h;
          if (v1 > 65535) v1 = 65535;
          pen_x = pen_x + q4(e.advance_x);
          pen_y = pen_y + q4(e.advance_y);
          queue_vertex(0, x2, y2, u0, 0, 1'b0);
          queue_vertex(1, x2, y2 + h16, u0, v1, 1'b0);
          queue_vertex(2, x2 + w16, y2 + h16, u1, v1, 1'b0);
          queue_vertex(3, x2, y2, u0, 0, 1'b0);
          queue_vertex(4, x2 + w16, y2 + h16, u1, v1, 1'b0);
          queue_vertex(5, x2 + w16, y2, u1, 0, 1'b0);
        end
      end
    end
    if (w.eos) begin
      pen_x        = '0;
      pen_y        = '0;
      string_muted = 1'b0;
    end
  endfunction

  function automatic char_word_t rand_word();
    char_word_t w;
    w.req_type     = gqv_pkg::REQ_CHAR;
    w.code         = gqv_pkg::CODE_W'($urandom);
    w.eos          = 1'b0;
    w.bearing_x    = gqv_pkg::MET_W'($urandom);
    w.bearing_y    = gqv_pkg::MET_W'($urandom);
    w.glyph_width  = gqv_pkg::MET_W'($urandom);
    w.glyph_height = gqv_pkg::MET_W'($urandom);
    w.advance_x    = gqv_pkg::MET_W'($urandom);
    w.advance_y    = gqv_pkg::MET_W'($urandom);
    w.atlas_u      = gqv_pkg::TEX_W'($urandom);
    return w;
  endfunction

  function automatic char_word_t char_word(input logic [gqv_pkg::CODE_W-1:0] code,
                                           input logic eos);
    char_word_t w;
    w      = rand_word();
    w.code = code;
    w.eos  = eos;
    return w;
  endfunction

  function automatic char_word_t glyph_write(input int idx);
    char_word_t w;
    w          = rand_word();
    w.req_type = gqv_pkg::REQ_GLYPH;
    w.code     = gqv_pkg::CODE_W'(idx);
    w.eos      = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) w.glyph_width = '0;
    else if ($urandom_range(9) == 0) w.glyph_height = '0;
    return w;
  endfunction

  function automatic char_word_t glyph_def(input int idx, input int bx, input int by,
                                           input int gw, input int gh, input int ax,
                                           input int ay, input int au);
    char_word_t w;
    w              = char_word(gqv_pkg::CODE_W'(idx), 1'b0);
    w.req_type     = gqv_pkg::REQ_GLYPH;
    w.bearing_x    = gqv_pkg::MET_W'(bx);
    w.bearing_y    = gqv_pkg::MET_W'(by);
    w.glyph_width  = gqv_pkg::MET_W'(gw);
    w.glyph_height = gqv_pkg::MET_W'(gh);
    w.advance_x    = gqv_pkg::MET_W'(ax);
    w.advance_y    = gqv_pkg::MET_W'(ay);
    w.atlas_u      = gqv_pkg::TEX_W'(au);
    return w;
  endfunction

  // loaded glyphs mostly, never an index that was not written
  function automatic logic [gqv_pkg::CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 70 && loaded_codes.size() > 0)
      return gqv_pkg::CODE_W'(loaded_codes[$urandom_range(loaded_codes.size() - 1)]);
    else if (r < 80) return gqv_pkg::CODE_SPACE;
    else if (r < 88) return gqv_pkg::CODE_NEWLINE;
    else if (r < 92) return gqv_pkg::CODE_NUL;
    return gqv_pkg::CODE_W'($urandom_range(255, GLYPH_COUNT));
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic send_word(input char_word_t w);
    @(negedge clk);
    while (in_gaps_on && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_req_type      = w.req_type;
    in_char_code     = w.code;
    in_end_of_string = w.eos;
    in_bearing_x     = w.bearing_x;
    in_bearing_y     = w.bearing_y;
    in_glyph_width   = w.glyph_width;
    in_glyph_height  = w.glyph_height;
    in_advance_x     = w.advance_x;
    in_advance_y     = w.advance_y;
    in_atlas_u       = w.atlas_u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vertices(w);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gqv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gqv_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gqv_pkg::REG_LINE_HEIGHT:     line_h = int'(data[gqv_pkg::LH_W-1:0]);
      gqv_pkg::REG_INV_CELL_WIDTH:  inv_w  = int'(data);
      gqv_pkg::REG_INV_CELL_HEIGHT: inv_h  = int'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [gqv_pkg::CFG_DATA_W-1:0] lh,
                            input logic [gqv_pkg::CFG_DATA_W-1:0] iw,
                            input logic [gqv_pkg::CFG_DATA_W-1:0] ih);
    wait_drained();
    write_reg(gqv_pkg::REG_LINE_HEIGHT, lh);
    write_reg(gqv_pkg::REG_INV_CELL_WIDTH, iw);
    write_reg(gqv_pkg::REG_INV_CELL_HEIGHT, ih);
  endtask

  task automatic send_random_string(input int max_len);
    int len;
    int i;
    len = $urandom_range(max_len, 1);
    if ($urandom_range(99) < 15) begin
      // noise: stray end flags, stray writes
      for (i = 0; i < len; i++) begin
        if ($urandom_range(3) == 0) send_word(glyph_write($urandom_range(255)));
        else send_word(char_word(pick_code(), 1'($urandom_range(1))));
      end
    end else begin
      for (i = 0; i < len; i++) begin
        if ($urandom_range(99) < 6) send_word(glyph_write($urandom_range(255)));
        else send_word(char_word(pick_code(), 1'b0));
      end
      send_word(char_word(pick_code(), 1'b1));
    end
  endtask

  task automatic test_directed_specials();
    char_word_t w;
    send_word(glyph_def(65, -128, 127, 255, 255, 127, -128, 16'hFFFF));
    send_word(glyph_def(66, 127, -128, 1, 1, -128, 127, 16'h0000));
    send_word(glyph_def(67, 3, 9, 0, 12, 7, 0, 16'h1234));
    send_word(glyph_def(68, 3, 9, 12, 0, 7, 0, 16'h4321));
    send_word(glyph_def(GLYPH_COUNT - 1, 0, 10, 8, 14, 9, 1, 16'h8000));
    w     = glyph_def(200, 1, 1, 255, 255, 1, 1, 16'h5555);
    w.eos = 1'b1;
    send_word(w);
    send_word(glyph_def(255, -1, -1, 255, 255, -1, -1, 16'hAAAA));
    send_word(char_word(8'd65, 1'b0));
    send_word(char_word(8'd66, 1'b0));
    send_word(char_word(gqv_pkg::CODE_W'(GLYPH_COUNT - 1), 1'b0));
    send_word(char_word(8'd67, 1'b0));
    send_word(char_word(8'd68, 1'b0));
    send_word(char_word(8'd200, 1'b0));
    send_word(char_word(gqv_pkg::CODE_NEWLINE, 1'b0));
    send_word(char_word(gqv_pkg::CODE_SPACE, 1'b0));
    send_word(char_word(8'd65, 1'b1));
    // NUL mutes the rest of the string, end flag on a muted char still resets
    send_word(char_word(8'd66, 1'b0));
    send_word(char_word(gqv_pkg::CODE_NUL, 1'b0));
    send_word(char_word(8'd65, 1'b0));
    send_word(char_word(gqv_pkg::CODE_NEWLINE, 1'b0));
    send_word(char_word(gqv_pkg::CODE_SPACE, 1'b1));
    send_word(char_word(8'd66, 1'b1));
  endtask

  task automatic test_config_extremes();
    int i;
    set_config(16'd1, 16'd1, 16'd1);
    for (i = 0; i < 2; i++) send_random_string(8);
    set_config(16'd1023, 16'hFFFF, 16'hFFFF);
    // long string of newlines at the largest line height, a glyph every eighth word
    for (i = 0; i < 66; i++) begin
      if (i % 8 == 7) send_word(char_word(8'd65, 1'b0));
      else send_word(char_word(gqv_pkg::CODE_NEWLINE, 1'b0));
    end
    send_word(char_word(8'd66, 1'b1));
    for (i = 0; i < 2; i++) send_random_string(8);
    // upper bits of the line height word are dropped
    set_config(16'hFC05, 16'd300, gqv_pkg::CFG_DATA_W'($urandom));
    for (i = 0; i < 2; i++) send_random_string(8);
    set_config(gqv_pkg::CFG_DATA_W'($urandom_range(1023, 1)),
               gqv_pkg::CFG_DATA_W'($urandom_range(65535, 1)),
               gqv_pkg::CFG_DATA_W'($urandom_range(65535, 1)));
    for (i = 0; i < 2; i++) send_random_string(8);
  endtask

  task automatic test_back_to_back();
    int stop_at;
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    stop_at     = words_sent + 30;
    while (words_sent < stop_at) send_random_string(10);
    wait_drained();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_output_hold_off();
    int i;
    @(posedge clk);
    hold_off_req = 80;
    for (i = 0; i < 24; i++) send_word(char_word(pick_code(), 1'b0));
    send_word(char_word(8'd65, 1'b1));
  endtask

  task automatic test_random_strings();
    int stop_at;
    stop_at = words_sent + 20;
    while (words_sent < stop_at) send_random_string(12);
  endtask

  always @(posedge clk) begin : vertex_check
    vertex_t expv;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        flag_error($sformatf("unexpected vertex: x=%0d y=%0d u=%0d v=%0d hole=%0b last=%0b",
                             out_vert_x, out_vert_y, out_tex_u, out_tex_v, out_is_hole,
                             out_last_vertex));
      end else begin
        expv = pending_vertices.pop_front();
        if (out_vert_x !== expv.x || out_vert_y !== expv.y || out_tex_u !== expv.u ||
            out_tex_v !== expv.v || out_is_hole !== expv.hole ||
            out_last_vertex !== expv.last) begin
          flag_error($sformatf({"vertex mismatch: exp x=%0d y=%0d u=%0d v=%0d hole=%0b ",
                                "last=%0b, got x=%0d y=%0d u=%0d v=%0d hole=%0b last=%0b"},
                               expv.x, expv.y, expv.u, expv.v, expv.hole, expv.last,
                               out_vert_x, out_vert_y, out_tex_u, out_tex_v, out_is_hole,
                               out_last_vertex));
        end
      end
    end
  end

  initial begin : out_stall_gen
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = out_gaps_on && ($urandom_range(99) < 15);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_glyph_quad_vertex_generator_core: done, errors");
    $finish;
  end

  initial begin : main_seq
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_req_type      = gqv_pkg::REQ_CHAR;
    in_char_code     = '0;
    in_end_of_string = 1'b0;
    in_bearing_x     = '0;
    in_bearing_y     = '0;
    in_glyph_width   = '0;
    in_glyph_height  = '0;
    in_advance_x     = '0;
    in_advance_y     = '0;
    in_atlas_u       = '0;
    cfg_valid        = 1'b0;
    cfg_index        = gqv_pkg::REG_LINE_HEIGHT;
    cfg_wdata        = '0;
    in_gaps_on       = 1'b1;
    out_gaps_on      = 1'b1;
    hold_off_req     = 0;
    pen_x            = '0;
    pen_y            = '0;
    string_muted     = 1'b0;
    line_h           = int'(gqv_pkg::LINE_HEIGHT_RST);
    inv_w            = int'(gqv_pkg::INV_CELL_RST);
    inv_h            = int'(gqv_pkg::INV_CELL_RST);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_specials();
    test_config_extremes();
    test_back_to_back();
    test_output_hold_off();
    test_random_strings();
    wait_drained();

    if (mismatch_count == 0 && pending_vertices.size() == 0)
      $display("tb_glyph_quad_vertex_generator_core: done, clean");
    else
      $display("tb_glyph_quad_vertex_generator_core: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/gqv_pkg.sv
rtl/glyph_quad_vertex_generator_core.sv
rtl/gqv_checker.sv
verif/tb_glyph_quad_vertex_generator_core.sv
